// ===== design/rabs_pkg.sv =====
package rabs_pkg;

   localparam int WAVELENGTH_COUNT_DEFAULT = 8;
   localparam int ADC_BITS_DEFAULT = 12;

   localparam int CONV_W = 12;
   localparam int SUM_W = 20;
   localparam int TAKEN_W = 8;
   localparam int WL_W = 3;
   localparam int NM_W = 10;
   localparam int LED_W = 8;
   localparam int THR_W = 12;
   localparam int ABS_W = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [TAKEN_W-1:0] SPA_RESET = 8'd16;
   localparam logic [THR_W-1:0] THR_RESET = 12'd4;
   localparam logic [ABS_W-1:0] DARK_ABS_RESET = 15'd12288;
   localparam logic [ABS_W-1:0] FULL_SCALE_ABS = 15'd16384;
   localparam logic [26:0] LOG10_2_Q28 = 27'd80807124;
   localparam logic [13:0] FLOOR_FACTOR = 14'd10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_AVERAGE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_ABSORBANCE = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [SUM_W-1:0] sample_sum;
      logic [SUM_W-1:0] reference_sum;
      logic [TAKEN_W-1:0] sample_taken;
      logic [TAKEN_W-1:0] reference_taken;
      logic [WL_W-1:0] wavelength;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_S,
      ST_AVG_R,
      ST_CLASSIFY,
      ST_NORM,
      ST_MDIV,
      ST_SQUARE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROUND,
      ST_OUT
   } back_state_type;

   function automatic logic [NM_W-1:0] nm_lookup(input logic [WL_W-1:0] w);
      logic [NM_W-1:0] nm;
      case (w)
         3'd0: nm = 10'd255;
         3'd1: nm = 10'd280;
         3'd2: nm = 10'd365;
         3'd3: nm = 10'd470;
         3'd4: nm = 10'd590;
         3'd5: nm = 10'd660;
         3'd6: nm = 10'd850;
         3'd7: nm = 10'd940;
         default: nm = 10'd0;
      endcase
      return nm;
   endfunction

endpackage

// ===== design/rabs_front.sv =====
module rabs_front #(
   parameter int WAVELENGTH_COUNT = rabs_pkg::WAVELENGTH_COUNT_DEFAULT,
   parameter int ADC_BITS = rabs_pkg::ADC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_mode,
   input  logic [rabs_pkg::CONV_W-1:0] req_conversion,
   input  logic [rabs_pkg::TAKEN_W-1:0] samples_per_average,
   input  logic queue_full,
   output logic queue_push,
   output rabs_pkg::job_type queue_job
);

   localparam logic [rabs_pkg::CONV_W-1:0] CONV_MASK = (ADC_BITS >= rabs_pkg::CONV_W) ?
      {rabs_pkg::CONV_W{1'b1}} : rabs_pkg::CONV_W'((1 << ADC_BITS) - 1);
   localparam logic [rabs_pkg::WL_W-1:0] WL_LAST = rabs_pkg::WL_W'(WAVELENGTH_COUNT - 1);

   logic [rabs_pkg::SUM_W-1:0] s_sum_ff, s_sum_in, r_sum_ff, r_sum_in;
   logic [rabs_pkg::TAKEN_W-1:0] s_taken_ff, s_taken_in, r_taken_ff, r_taken_in;
   logic [rabs_pkg::WL_W-1:0] wl_ff, wl_in;
   logic [rabs_pkg::TAKEN_W-1:0] n;
   logic [rabs_pkg::CONV_W-1:0] conv;
   logic accept;
   logic complete;

   assign req_full = queue_full;
   assign accept = req_push && !queue_full;
   assign n = (samples_per_average == '0) ? rabs_pkg::TAKEN_W'(1) : samples_per_average;
   assign conv = req_conversion & CONV_MASK;

   always_comb begin
      s_sum_in = s_sum_ff;
      r_sum_in = r_sum_ff;
      s_taken_in = s_taken_ff;
      r_taken_in = r_taken_ff;
      wl_in = wl_ff;
      complete = 1'b0;
      if (accept) begin
         if (!req_mode && s_taken_ff < n) begin
            s_sum_in = s_sum_ff + rabs_pkg::SUM_W'(conv);
            s_taken_in = s_taken_ff + 1'b1;
         end
         if (req_mode && r_taken_ff < n) begin
            r_sum_in = r_sum_ff + rabs_pkg::SUM_W'(conv);
            r_taken_in = r_taken_ff + 1'b1;
         end
         complete = (s_taken_in >= n) && (r_taken_in >= n);
      end
      queue_job.sample_sum = s_sum_in;
      queue_job.reference_sum = r_sum_in;
      queue_job.sample_taken = s_taken_in;
      queue_job.reference_taken = r_taken_in;
      queue_job.wavelength = wl_ff;
      queue_push = complete;
      if (complete) begin
         s_sum_in = '0;
         r_sum_in = '0;
         s_taken_in = '0;
         r_taken_in = '0;
         wl_in = (wl_ff == WL_LAST) ? '0 : wl_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_sum_ff <= '0;
         r_sum_ff <= '0;
         s_taken_ff <= '0;
         r_taken_ff <= '0;
         wl_ff <= '0;
      end else begin
         s_sum_ff <= s_sum_in;
         r_sum_ff <= r_sum_in;
         s_taken_ff <= s_taken_in;
         r_taken_ff <= r_taken_in;
         wl_ff <= wl_in;
      end
   end

endmodule

// ===== design/rabs_queue.sv =====
module rabs_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic pop,
   output logic empty,
   input  rabs_pkg::job_type push_job,
   output rabs_pkg::job_type pop_job
);

   rabs_pkg::job_type mem_ff [rabs_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'(rabs_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/rabs_back.sv =====
module rabs_back #(
   parameter int WAVELENGTH_COUNT = rabs_pkg::WAVELENGTH_COUNT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic queue_empty,
   output logic queue_pop,
   input  rabs_pkg::job_type queue_job,
   input  logic [rabs_pkg::THR_W-1:0] dark_threshold,
   input  logic [rabs_pkg::ABS_W-1:0] dark_absorbance,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [rabs_pkg::WL_W-1:0] rsp_wavelength_index,
   output logic [rabs_pkg::NM_W-1:0] rsp_wavelength_nm,
   output logic [rabs_pkg::LED_W-1:0] rsp_led_select,
   output logic [rabs_pkg::ABS_W-1:0] rsp_absorbance,
   output logic rsp_dark_reference,
   output logic rsp_ratio_floored,
   output logic rsp_last
);

   localparam logic [rabs_pkg::WL_W-1:0] WL_LAST = rabs_pkg::WL_W'(WAVELENGTH_COUNT - 1);

   rabs_pkg::back_state_type state_ff, state_in;
   rabs_pkg::job_type job_ff, job_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [7:0] rem_ff, rem_in;
   logic [19:0] quo_ff, quo_in;
   logic [11:0] s_ff, s_in, r_ff, r_in;
   logic [12:0] d_ff, d_in;
   logic [3:0] e_ff, e_in;
   logic [13:0] mrem_ff, mrem_in;
   logic [30:0] m_ff, m_in;
   logic [29:0] frac_ff, frac_in;
   logic [43:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [rabs_pkg::ABS_W-1:0] abs_ff, abs_in;
   logic dark_ff, dark_in, floored_ff, floored_in;
   logic out_valid_ff, out_valid_in;
   logic [rabs_pkg::WL_W-1:0] out_wl_ff, out_wl_in;
   logic [rabs_pkg::ABS_W-1:0] out_abs_ff, out_abs_in;
   logic out_dark_ff, out_dark_in, out_floored_ff, out_floored_in;

   logic [19:0] dividend;
   logic [7:0] divisor;
   logic [8:0] remx;
   logic [13:0] mtry;
   logic [61:0] sq;
   logic [31:0] mm;
   logic [33:0] l2;
   logic [61:0] prod;
   logic [15:0] q;

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      s_in = s_ff;
      r_in = r_ff;
      d_in = d_ff;
      e_in = e_ff;
      mrem_in = mrem_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      abs_in = abs_ff;
      dark_in = dark_ff;
      floored_in = floored_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_wl_in = out_wl_ff;
      out_abs_in = out_abs_ff;
      out_dark_in = out_dark_ff;
      out_floored_in = out_floored_ff;
      queue_pop = 1'b0;

      dividend = (state_ff == rabs_pkg::ST_AVG_S) ? job_ff.sample_sum : job_ff.reference_sum;
      divisor = (state_ff == rabs_pkg::ST_AVG_S) ? job_ff.sample_taken :
         job_ff.reference_taken;
      remx = {rem_ff, dividend[cnt_ff]};
      mtry = mrem_ff - {1'b0, d_ff};
      sq = 62'(m_ff) * 62'(m_ff);
      mm = sq[61:30];
      l2 = {e_ff, frac_ff};
      prod = {1'b0, phi_ff, 17'b0} + {18'b0, plo_ff} + (62'd1 << 45);
      q = prod[61:46];

      case (state_ff)
         rabs_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in = queue_job;
               cnt_in = 5'd19;
               rem_in = '0;
               state_in = rabs_pkg::ST_AVG_S;
            end
         end
         rabs_pkg::ST_AVG_S, rabs_pkg::ST_AVG_R: begin
            if (remx >= {1'b0, divisor}) begin
               rem_in = 8'(remx - {1'b0, divisor});
               quo_in = {quo_ff[18:0], 1'b1};
            end else begin
               rem_in = remx[7:0];
               quo_in = {quo_ff[18:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in = '0;
               cnt_in = 5'd19;
               if (state_ff == rabs_pkg::ST_AVG_S) begin
                  s_in = quo_in[11:0];
                  state_in = rabs_pkg::ST_AVG_R;
               end else begin
                  r_in = quo_in[11:0];
                  state_in = rabs_pkg::ST_CLASSIFY;
               end
            end
         end
         rabs_pkg::ST_CLASSIFY: begin
            dark_in = 1'b0;
            floored_in = 1'b0;
            d_in = {1'b0, s_ff};
            e_in = '0;
            if (r_ff < dark_threshold) begin
               dark_in = 1'b1;
               abs_in = dark_absorbance;
               state_in = rabs_pkg::ST_OUT;
            end else if ((26'(s_ff) * 26'(rabs_pkg::FLOOR_FACTOR)) < 26'(r_ff)) begin
               floored_in = 1'b1;
               abs_in = rabs_pkg::FULL_SCALE_ABS;
               state_in = rabs_pkg::ST_OUT;
            end else if (s_ff >= r_ff) begin
               abs_in = '0;
               state_in = rabs_pkg::ST_OUT;
            end else begin
               state_in = rabs_pkg::ST_NORM;
            end
         end
         rabs_pkg::ST_NORM: begin
            if ({d_ff, 1'b0} <= 14'(r_ff)) begin
               d_in = {d_ff[11:0], 1'b0};
               e_in = e_ff + 1'b1;
            end else begin
               mrem_in = 14'(r_ff);
               cnt_in = 5'd30;
               state_in = rabs_pkg::ST_MDIV;
            end
         end
         rabs_pkg::ST_MDIV: begin
            if (mrem_ff >= {1'b0, d_ff}) begin
               m_in = {m_ff[29:0], 1'b1};
               mrem_in = {mtry[12:0], 1'b0};
            end else begin
               m_in = {m_ff[29:0], 1'b0};
               mrem_in = {mrem_ff[12:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in = 5'd29;
               frac_in = '0;
               state_in = rabs_pkg::ST_SQUARE;
            end
         end
         rabs_pkg::ST_SQUARE: begin
            if (mm[31]) begin
               m_in = mm[31:1];
               frac_in = {frac_ff[28:0], 1'b1};
            end else begin
               m_in = mm[30:0];
               frac_in = {frac_ff[28:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = rabs_pkg::ST_MUL_LO;
            end
         end
         rabs_pkg::ST_MUL_LO: begin
            plo_in = 44'(l2[16:0]) * 44'(rabs_pkg::LOG10_2_Q28);
            state_in = rabs_pkg::ST_MUL_HI;
         end
         rabs_pkg::ST_MUL_HI: begin
            phi_in = 44'(l2[33:17]) * 44'(rabs_pkg::LOG10_2_Q28);
            state_in = rabs_pkg::ST_ROUND;
         end
         rabs_pkg::ST_ROUND: begin
            abs_in = (q > 16'(rabs_pkg::FULL_SCALE_ABS)) ? rabs_pkg::FULL_SCALE_ABS :
               q[rabs_pkg::ABS_W-1:0];
            state_in = rabs_pkg::ST_OUT;
         end
         rabs_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_wl_in = job_ff.wavelength;
               out_abs_in = abs_ff;
               out_dark_in = dark_ff;
               out_floored_in = floored_ff;
               state_in = rabs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rabs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rabs_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      s_ff <= s_in;
      r_ff <= r_in;
      d_ff <= d_in;
      e_ff <= e_in;
      mrem_ff <= mrem_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      abs_ff <= abs_in;
      dark_ff <= dark_in;
      floored_ff <= floored_in;
      out_wl_ff <= out_wl_in;
      out_abs_ff <= out_abs_in;
      out_dark_ff <= out_dark_in;
      out_floored_ff <= out_floored_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_wavelength_index = out_wl_ff;
   assign rsp_wavelength_nm = rabs_pkg::nm_lookup(out_wl_ff);
   assign rsp_led_select = rabs_pkg::LED_W'(1) << out_wl_ff;
   assign rsp_absorbance = out_abs_ff;
   assign rsp_dark_reference = out_dark_ff;
   assign rsp_ratio_floored = out_floored_ff;
   assign rsp_last = (out_wl_ff == WL_LAST);

endmodule

// ===== design/ratiometric_absorbance_sweep_core.sv =====
// Conversions are taken one per cycle whenever full is low; the front end adds each conversion
// to its channel's total until that channel holds samples_per_average of them and drops surplus
// ones. Each completed pair of totals is passed through a two-entry queue to the back end, which
// produces one absorbance per job: directly when the reference is dark, the ratio is floored or
// the sample is not below the reference, and otherwise through a logarithm: two bit-serial average
// divisions, normalising shifts of the divisor, a bit-serial mantissa division, 30 squarings in
// one 31 x 31 multiplier, and the ST_MUL_LO, ST_MUL_HI and ST_ROUND states of scaling and rounding.
// The result waits in an output register until popped while the next job proceeds.
// Configuration writes are always ready and must only be made while the block is idle.
module ratiometric_absorbance_sweep_core #(
   parameter int WAVELENGTH_COUNT = rabs_pkg::WAVELENGTH_COUNT_DEFAULT,
   parameter int ADC_BITS = rabs_pkg::ADC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic full,
   input  logic req_mode,
   input  logic [rabs_pkg::CONV_W-1:0] req_conversion,
   output logic empty,
   input  logic pop,
   output logic [rabs_pkg::WL_W-1:0] rsp_wavelength_index,
   output logic [rabs_pkg::NM_W-1:0] rsp_wavelength_nm,
   output logic [rabs_pkg::LED_W-1:0] rsp_led_select,
   output logic [rabs_pkg::ABS_W-1:0] rsp_absorbance,
   output logic rsp_dark_reference,
   output logic rsp_ratio_floored,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rabs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rabs_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [rabs_pkg::TAKEN_W-1:0] spa_ff, spa_in;
   logic [rabs_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [rabs_pkg::ABS_W-1:0] dark_abs_ff, dark_abs_in;
   logic q_push, q_full, q_pop, q_empty;
   rabs_pkg::job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   always_comb begin
      spa_in = spa_ff;
      thr_in = thr_ff;
      dark_abs_in = dark_abs_ff;
      if (csr_valid) begin
         case (csr_index)
            rabs_pkg::CSR_SAMPLES_PER_AVERAGE: spa_in = csr_data[rabs_pkg::TAKEN_W-1:0];
            rabs_pkg::CSR_DARK_THRESHOLD: thr_in = csr_data[rabs_pkg::THR_W-1:0];
            rabs_pkg::CSR_DARK_ABSORBANCE: dark_abs_in = csr_data[rabs_pkg::ABS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spa_ff <= rabs_pkg::SPA_RESET;
         thr_ff <= rabs_pkg::THR_RESET;
         dark_abs_ff <= rabs_pkg::DARK_ABS_RESET;
      end else begin
         spa_ff <= spa_in;
         thr_ff <= thr_in;
         dark_abs_ff <= dark_abs_in;
      end
   end

   rabs_front #(
      .WAVELENGTH_COUNT(WAVELENGTH_COUNT),
      .ADC_BITS(ADC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(full),
      .req_mode(req_mode),
      .req_conversion(req_conversion),
      .samples_per_average(spa_ff),
      .queue_full(q_full),
      .queue_push(q_push),
      .queue_job(push_job)
   );

   rabs_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .push_job(push_job),
      .pop_job(pop_job)
   );

   rabs_back #(
      .WAVELENGTH_COUNT(WAVELENGTH_COUNT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(q_empty),
      .queue_pop(q_pop),
      .queue_job(pop_job),
      .dark_threshold(thr_ff),
      .dark_absorbance(dark_abs_ff),
      .rsp_empty(empty),
      .rsp_pop(pop),
      .rsp_wavelength_index(rsp_wavelength_index),
      .rsp_wavelength_nm(rsp_wavelength_nm),
      .rsp_led_select(rsp_led_select),
      .rsp_absorbance(rsp_absorbance),
      .rsp_dark_reference(rsp_dark_reference),
      .rsp_ratio_floored(rsp_ratio_floored),
      .rsp_last(rsp_last)
   );

endmodule

// ===== design/rabs_checker.sv =====
module rabs_checker #(
   parameter int WAVELENGTH_COUNT = rabs_pkg::WAVELENGTH_COUNT_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic empty,
   input logic pop,
   input logic [rabs_pkg::WL_W-1:0] rsp_wavelength_index,
   input logic [rabs_pkg::LED_W-1:0] rsp_led_select,
   input logic [rabs_pkg::ABS_W-1:0] rsp_absorbance,
   input logic rsp_dark_reference,
   input logic rsp_ratio_floored,
   input logic rsp_last
);

   localparam logic [rabs_pkg::WL_W-1:0] WL_LAST = rabs_pkg::WL_W'(WAVELENGTH_COUNT - 1);

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("Result withdrawn before its transfer.");

   a_led_matches_index: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($onehot(rsp_led_select) &&
      rsp_led_select[rsp_wavelength_index])) else $error("LED select does not match index.");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last == (rsp_wavelength_index == WL_LAST)))
      else $error("Last flag does not match the final wavelength.");

   a_floor_consistent: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_ratio_floored) |-> (!rsp_dark_reference &&
      rsp_absorbance == rabs_pkg::FULL_SCALE_ABS))
      else $error("Floored ratio without full-scale absorbance.");

endmodule

bind ratiometric_absorbance_sweep_core rabs_checker #(
   .WAVELENGTH_COUNT(WAVELENGTH_COUNT)
) u_rabs_checker (.*);
